// ===== rtl/ndbox_pkg.sv =====
// Shared types and constants for the N-dimensional box overlap copy descriptor generator.
// Used by the controller, the datapath, the multiply-accumulate unit and the top level.
package ndbox_pkg;

  localparam int unsigned MaxDimsDef = 8;
  localparam int unsigned OffW       = 48;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_FETCH = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [OffW-1:0] Mask48 = {OffW{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // an input transaction is accepted this cycle
    logic load;   // append the captured dimension
    logic clear;  // return the job to its reset state
    logic quick;  // emit the scalar or empty-overlap descriptor
    logic init;   // clear the accumulators and the dimension counter
    logic ph_a;   // first half of a multiply-accumulate step
    logic ph_b;   // second half; outside scaling and before the last dimension it also advances the dimension counter
    logic scale;  // the step multiplies by the element size
    logic emit;   // register the descriptor and update the job state
  } ndbox_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;
    logic empty;
    logic done;
    logic last_dim;
  } ndbox_st_t;

endpackage

// ===== rtl/ndbox_mac.sv =====
// 48-bit by 32-bit multiply-accumulate, split into half-width phases A and B, with optional saturation at 2^48-1.
// Depends on ndbox_pkg.
module ndbox_mac import ndbox_pkg::*; (
  input  logic            clk_i,
  input  logic            clr_i,
  input  logic            init_one_i,
  input  logic            ph_a_i,
  input  logic            ph_b_i,
  input  logic            en_i,
  input  logic            sat_i,
  input  logic [31:0]     mul_i,
  input  logic [31:0]     add_i,
  output logic [OffW-1:0] acc_o
);

  logic [55:0]     lo_q, lo_d;
  logic [OffW-1:0] acc_q, acc_d;
  logic [55:0]     hi_prod;
  logic [79:0]     full;

  always_comb begin
    hi_prod = 56'(acc_q[47:24]) * 56'(mul_i);
    full    = {hi_prod, 24'b0} + {24'b0, lo_q} + {48'b0, add_i};
    lo_d    = lo_q;
    acc_d   = acc_q;
    if (clr_i) begin
      acc_d = init_one_i ? OffW'(1) : '0;
    end else if (en_i && ph_a_i) begin
      lo_d = 56'(acc_q[23:0]) * 56'(mul_i);
    end else if (en_i && ph_b_i) begin
      // With saturation enabled, a result that overflows 48 bits is clamped to all ones.
      if (sat_i && (full[79:48] != '0)) begin
        acc_d = Mask48;
      end else begin
        acc_d = full[47:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/ndbox_ctrl.sv =====
// Controller state machine: sequences loads, clears, quick fetches, the per-dimension offset steps and the emit.
// Depends on ndbox_pkg.
module ndbox_ctrl import ndbox_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] command_i,
  input  ndbox_st_t  st_i,
  output ndbox_ctl_t ctl_o,
  output logic       busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_CLEAR, S_QUICK, S_INIT, S_MA, S_MB, S_SA, S_SB, S_EMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start) begin
            case (command_i)
              CMD_LOAD:  state_q <= S_LOAD;
              CMD_CLEAR: state_q <= S_CLEAR;
              CMD_FETCH: begin
                if (st_i.done) begin
                  state_q <= S_IDLE;
                end else if (st_i.n_zero || st_i.empty) begin
                  state_q <= S_QUICK;
                end else begin
                  state_q <= S_INIT;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_INIT: state_q <= S_MA;
        S_MA:   state_q <= S_MB;
        S_MB:   state_q <= st_i.last_dim ? S_SA : S_MA;
        S_SA:   state_q <= S_SB;
        S_SB:   state_q <= S_EMIT;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctl_o       = '0;
    ctl_o.take  = start && (state_q == S_IDLE);
    ctl_o.load  = (state_q == S_LOAD);
    ctl_o.clear = (state_q == S_CLEAR);
    ctl_o.quick = (state_q == S_QUICK);
    ctl_o.init  = (state_q == S_INIT);
    ctl_o.ph_a  = (state_q == S_MA) || (state_q == S_SA);
    ctl_o.ph_b  = (state_q == S_MB) || (state_q == S_SB);
    ctl_o.scale = (state_q == S_SA) || (state_q == S_SB);
    ctl_o.emit  = (state_q == S_EMIT);
  end

  assign busy = (state_q != S_IDLE);

`ifndef ASSERT_OFF
  a_mb_follows_ma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MB) |-> $past(state_q == S_MA))
    else $error("multiply step B without step A");
  a_emit_after_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> $past(state_q == S_SB))
    else $error("descriptor emitted without scaling");
  a_no_fetch_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.take && command_i == CMD_FETCH && st_i.done) |=> (state_q == S_IDLE))
    else $error("exhausted job started a fetch");
`endif

endmodule

// ===== rtl/ndbox_dp.sv =====
// Datapath: bound storage, overlap and odometer registers, three multiply-accumulate units
// and the result registers. Depends on ndbox_pkg and ndbox_mac.
module ndbox_dp import ndbox_pkg::*; #(
  parameter int unsigned MAX_DIMS = MaxDimsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ndbox_ctl_t      ctl_i,
  output ndbox_st_t       st_o,
  input  logic [31:0]     src_low_i,
  input  logic [31:0]     src_high_i,
  input  logic [31:0]     dst_low_i,
  input  logic [31:0]     dst_high_i,
  input  logic [7:0]      element_bytes_i,
  output logic            valid_o,
  output logic [OffW-1:0] src_byte_offset_o,
  output logic [OffW-1:0] dst_byte_offset_o,
  output logic [OffW-1:0] byte_length_o,
  output logic            last_chunk_o,
  output logic            no_overlap_o
);

  localparam int unsigned DimW = $clog2(MAX_DIMS + 1);
  localparam int unsigned IdxW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // Captured input transaction.
  logic [31:0] in_sl_q, in_sh_q, in_dl_q, in_dh_q;
  logic [7:0]  in_eb_q;

  logic [31:0] sl_q [MAX_DIMS];
  logic [31:0] sh_q [MAX_DIMS];
  logic [31:0] dl_q [MAX_DIMS];
  logic [31:0] dh_q [MAX_DIMS];
  logic [31:0] ol_q [MAX_DIMS];
  logic [31:0] oh_q [MAX_DIMS];
  logic [31:0] pos_q [MAX_DIMS];
  logic [31:0] pos_d [MAX_DIMS];

  logic [DimW-1:0] dims_q;
  logic [IdxW-1:0] idx_q;
  logic [7:0]      esz_q;
  logic [OffW-1:0] run_q;
  logic            done_q, empty_q, ncont_q, valid_q;

  logic [OffW-1:0] src_q, dst_q, len_q;
  logic            last_q, none_q;

  logic [31:0] new_ol, new_oh, sel_pos;
  logic [31:0] mul_s, mul_d, mul_t, add_s, add_d;
  logic        last_dim, contig, en_t, job_last, carry;
  logic [OffW-1:0] acc_s, acc_d, acc_t, chunk_len;
  logic [IdxW-1:0] wr_idx;

  assign new_ol  = (in_sl_q > in_dl_q) ? in_sl_q : in_dl_q;
  assign new_oh  = (in_sh_q < in_dh_q) ? in_sh_q : in_dh_q;
  assign wr_idx  = dims_q[IdxW-1:0];
  assign contig  = !ncont_q;
  assign last_dim = (DimW'(idx_q) + DimW'(1)) == dims_q;

  // The innermost dimension and the contiguous case always start at the overlap low.
  assign sel_pos = (contig || last_dim) ? ol_q[idx_q] : pos_q[idx_q];

  always_comb begin
    if (ctl_i.scale) begin
      mul_s = 32'(esz_q);
      mul_d = 32'(esz_q);
      mul_t = 32'(esz_q);
      add_s = '0;
      add_d = '0;
      en_t  = contig;
    end else begin
      mul_s = sh_q[idx_q] - sl_q[idx_q];
      mul_d = dh_q[idx_q] - dl_q[idx_q];
      mul_t = oh_q[idx_q] - ol_q[idx_q];
      add_s = sel_pos - sl_q[idx_q];
      add_d = sel_pos - dl_q[idx_q];
      en_t  = contig || !last_dim;
    end
  end

  ndbox_mac u_mac_src (
    .clk_i, .clr_i(ctl_i.init), .init_one_i(1'b0), .ph_a_i(ctl_i.ph_a),
    .ph_b_i(ctl_i.ph_b), .en_i(1'b1), .sat_i(1'b0), .mul_i(mul_s), .add_i(add_s),
    .acc_o(acc_s)
  );
  ndbox_mac u_mac_dst (
    .clk_i, .clr_i(ctl_i.init), .init_one_i(1'b0), .ph_a_i(ctl_i.ph_a),
    .ph_b_i(ctl_i.ph_b), .en_i(1'b1), .sat_i(1'b0), .mul_i(mul_d), .add_i(add_d),
    .acc_o(acc_d)
  );
  // Holds the total byte length when contiguous, otherwise the saturating run count.
  ndbox_mac u_mac_cnt (
    .clk_i, .clr_i(ctl_i.init), .init_one_i(1'b1), .ph_a_i(ctl_i.ph_a),
    .ph_b_i(ctl_i.ph_b), .en_i(en_t), .sat_i(ncont_q), .mul_i(mul_t), .add_i(32'd0),
    .acc_o(acc_t)
  );

  assign chunk_len = OffW'((oh_q[idx_q] - ol_q[idx_q]) * 40'(esz_q));
  assign job_last  = contig || (({1'b0, run_q} + 49'd1) >= {1'b0, acc_t});

  // Odometer over all dimensions but the innermost; the carry ripples outwards.
  always_comb begin
    carry = 1'b1;
    for (int d = MAX_DIMS - 1; d >= 0; d--) begin
      pos_d[d] = pos_q[d];
      if ((d + 1) < int'(dims_q)) begin
        if (carry) begin
          pos_d[d] = ((pos_q[d] + 32'd1) == oh_q[d]) ? ol_q[d] : pos_q[d] + 32'd1;
        end
        carry = carry && ((pos_q[d] + 32'd1) == oh_q[d]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      in_sl_q <= src_low_i;
      in_sh_q <= src_high_i;
      in_dl_q <= dst_low_i;
      in_dh_q <= dst_high_i;
      in_eb_q <= element_bytes_i;
    end
    if (ctl_i.load && (dims_q < DimW'(MAX_DIMS))) begin
      sl_q[wr_idx] <= in_sl_q;
      sh_q[wr_idx] <= in_sh_q;
      dl_q[wr_idx] <= in_dl_q;
      dh_q[wr_idx] <= in_dh_q;
      ol_q[wr_idx] <= new_ol;
      oh_q[wr_idx] <= new_oh;
      for (int d = 0; d < MAX_DIMS; d++) begin
        pos_q[d] <= (IdxW'(d) == wr_idx) ? new_ol : ol_q[d];
      end
    end else if (ctl_i.emit && !job_last) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        pos_q[d] <= pos_d[d];
      end
    end
    if (ctl_i.emit) begin
      src_q  <= acc_s;
      dst_q  <= acc_d;
      len_q  <= contig ? acc_t : chunk_len;
      last_q <= job_last;
      none_q <= 1'b0;
    end else if (ctl_i.quick) begin
      src_q  <= '0;
      dst_q  <= '0;
      len_q  <= (dims_q == '0) ? OffW'(esz_q) : '0;
      last_q <= 1'b1;
      none_q <= (dims_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= '0;
      idx_q   <= '0;
      esz_q   <= 8'd1;
      run_q   <= '0;
      done_q  <= 1'b0;
      empty_q <= 1'b0;
      ncont_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.emit || ctl_i.quick;
      if (ctl_i.clear) begin
        dims_q  <= '0;
        esz_q   <= 8'd1;
        run_q   <= '0;
        done_q  <= 1'b0;
        empty_q <= 1'b0;
        ncont_q <= 1'b0;
      end else if (ctl_i.load && (dims_q < DimW'(MAX_DIMS))) begin
        dims_q  <= dims_q + DimW'(1);
        esz_q   <= in_eb_q;
        run_q   <= '0;
        done_q  <= 1'b0;
        empty_q <= empty_q || (new_ol >= new_oh);
        if (dims_q != '0) begin
          ncont_q <= ncont_q || (new_ol != in_sl_q) || (new_oh != in_sh_q) ||
                     (new_ol != in_dl_q) || (new_oh != in_dh_q);
        end
      end else if (ctl_i.quick) begin
        done_q <= 1'b1;
      end else if (ctl_i.emit) begin
        if (job_last) begin
          done_q <= 1'b1;
        end else begin
          run_q <= run_q + OffW'(1);
        end
      end
      if (ctl_i.init) begin
        idx_q <= '0;
      end else if (ctl_i.ph_b && !ctl_i.scale && !last_dim) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_comb begin
    st_o          = '0;
    st_o.n_zero   = (dims_q == '0);
    st_o.empty    = empty_q;
    st_o.done     = done_q;
    st_o.last_dim = last_dim;
  end

  assign valid_o           = valid_q;
  assign src_byte_offset_o = src_q;
  assign dst_byte_offset_o = dst_q;
  assign byte_length_o     = len_q;
  assign last_chunk_o      = last_q;
  assign no_overlap_o      = none_q;

`ifndef ASSERT_OFF
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(ctl_i.emit || ctl_i.quick))
    else $error("result strobe without an emit command");
  a_dims_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dims_q <= DimW'(MAX_DIMS))
    else $error("dimension count beyond its limit");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> done_q)
    else $error("last descriptor left the job open");
`endif

endmodule

// ===== rtl/nd_box_overlap_copy_descriptors_top.sv =====
// Top level of the N-dimensional box overlap copy descriptor generator.
// Depends on ndbox_pkg, ndbox_ctrl, ndbox_dp and ndbox_mac.
//
// A transaction is taken when start is high and busy is low. A fetch of the scalar or
// empty-overlap descriptor goes straight to the result registers; any other fetch is worked
// out by the multiply-accumulate units, which walk the dimensions one at a time in two
// half-width multiply steps each and then scale by the element size. The descriptor appears
// on the result ports for one cycle with valid_o high, in the cycle in which busy falls; the
// receiver cannot stall and must take it then. A fetch on an exhausted job, and command 3,
// give no result.
module nd_box_overlap_copy_descriptors_top import ndbox_pkg::*; #(
  parameter int unsigned MAX_DIMS = MaxDimsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      command_i,
  input  logic [31:0]     src_low_i,
  input  logic [31:0]     src_high_i,
  input  logic [31:0]     dst_low_i,
  input  logic [31:0]     dst_high_i,
  input  logic [7:0]      element_bytes_i,
  output logic            valid_o,
  output logic [OffW-1:0] src_byte_offset_o,
  output logic [OffW-1:0] dst_byte_offset_o,
  output logic [OffW-1:0] byte_length_o,
  output logic            last_chunk_o,
  output logic            no_overlap_o
);

  ndbox_ctl_t ctl;
  ndbox_st_t  st;

  ndbox_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .command_i, .st_i(st), .ctl_o(ctl), .busy
  );

  ndbox_dp #(.MAX_DIMS(MAX_DIMS)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .st_o(st),
    .src_low_i, .src_high_i, .dst_low_i, .dst_high_i, .element_bytes_i,
    .valid_o, .src_byte_offset_o, .dst_byte_offset_o, .byte_length_o,
    .last_chunk_o, .no_overlap_o
  );

endmodule

// ===== bench/tb_nd_box_overlap_copy_descriptors_top.sv =====
// Testbench for nd_box_overlap_copy_descriptors_top: directed and random command streams,
// checked against a behavioural predictor of the descriptor sequence. Depends on ndbox_pkg.
module tb_nd_box_overlap_copy_descriptors_top;
  import ndbox_pkg::*;

  localparam int unsigned Dims = MaxDimsDef;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [63:0] RunCap = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] sl, sh, dl, dh;
    logic [7:0]  eb;
  } box_cmd_t;

  typedef struct {
    logic [47:0] src_off, dst_off, len;
    logic        last, none;
  } descriptor_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = CMD_CLEAR;
  logic [31:0] src_low_i = '0, src_high_i = '0, dst_low_i = '0, dst_high_i = '0;
  logic [7:0]  element_bytes_i = 8'd1;
  logic        valid_o;
  logic [47:0] src_byte_offset_o, dst_byte_offset_o, byte_length_o;
  logic        last_chunk_o, no_overlap_o;

  nd_box_overlap_copy_descriptors_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  int unsigned m_dims;
  logic [31:0] m_sl[Dims], m_sh[Dims], m_dl[Dims], m_dh[Dims], m_ol[Dims], m_oh[Dims];
  logic [7:0]  m_esz;
  logic [63:0] m_run;
  bit          m_done;

  box_cmd_t    pending_cmds[$];
  descriptor_t expected_descs[$];
  box_cmd_t    cur_cmd;
  int unsigned issued = 0;
  int unsigned mismatches = 0;
  bit          stimulus_ready = 1'b0;

  task automatic clear_job();
    m_dims = 0;
    m_esz  = 8'd1;
    m_run  = '0;
    m_done = 1'b0;
  endtask

  task automatic queue_cmd(input box_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  function automatic logic [63:0] row_major(input logic [31:0] pos[Dims], input bit dst_side);
    logic [63:0] off, stride;
    logic [31:0] lo, hi;
    off = 64'd0;
    stride = 64'd1;
    for (int d = int'(m_dims) - 1; d >= 0; d--) begin
      lo = dst_side ? m_dl[d] : m_sl[d];
      hi = dst_side ? m_dh[d] : m_sh[d];
      off += 64'(pos[d] - lo) * stride;
      stride *= 64'(hi - lo);
    end
    return off;
  endfunction

  task automatic push_desc(input logic [63:0] s, t, len, input bit last, none);
    descriptor_t e;
    e.src_off = s[47:0];
    e.dst_off = t[47:0];
    e.len     = len[47:0];
    e.last    = last;
    e.none    = none;
    expected_descs.insert(expected_descs.size(), e);
  endtask

  // Applies one accepted transaction to the predictor and queues any descriptor it yields.
  task automatic predict_descriptor(input box_cmd_t c);
    logic [31:0] pos[Dims];
    logic [63:0] esz, total, runs, r, w, so, dso;
    bit contiguous, last;
    int n;
    n = int'(m_dims);
    if (c.cmd == CMD_LOAD) begin
      if (m_dims < Dims) begin
        m_sl[n] = c.sl; m_sh[n] = c.sh; m_dl[n] = c.dl; m_dh[n] = c.dh;
        m_ol[n] = c.sl > c.dl ? c.sl : c.dl;
        m_oh[n] = c.sh < c.dh ? c.sh : c.dh;
        m_esz  = c.eb;
        m_dims = m_dims + 1;
        m_run  = '0;
        m_done = 1'b0;
      end
      return;
    end
    if (c.cmd == CMD_CLEAR) begin
      clear_job();
      return;
    end
    if (c.cmd != CMD_FETCH || m_done) return;
    m_done = 1'b1;
    esz = 64'(m_esz);
    if (n == 0) begin
      push_desc(64'd0, 64'd0, esz, 1'b1, 1'b0);
      return;
    end
    for (int d = 0; d < n; d++)
      if (m_ol[d] >= m_oh[d]) begin
        push_desc(64'd0, 64'd0, 64'd0, 1'b1, 1'b1);
        return;
      end
    contiguous = 1'b1;
    for (int d = 1; d < n; d++)
      if (m_ol[d] != m_sl[d] || m_oh[d] != m_sh[d] || m_ol[d] != m_dl[d] || m_oh[d] != m_dh[d])
        contiguous = 1'b0;
    if (contiguous) begin
      total = 64'd1;
      for (int d = 0; d < n; d++) total *= 64'(m_oh[d] - m_ol[d]);
      so  = row_major(m_ol, 1'b0);
      dso = row_major(m_ol, 1'b1);
      push_desc(so * esz, dso * esz, total * esz, 1'b1, 1'b0);
      return;
    end
    // One descriptor per innermost run; the run count saturates at 48 bits.
    runs = 64'd1;
    for (int d = 0; d < n - 1; d++) begin
      w = 64'(m_oh[d] - m_ol[d]);
      if (runs > RunCap / w) runs = RunCap;
      else runs *= w;
    end
    r = m_run;
    foreach (pos[d]) pos[d] = m_ol[d];
    for (int d = n - 2; d >= 0; d--) begin
      w = 64'(m_oh[d] - m_ol[d]);
      pos[d] = m_ol[d] + 32'(r % w);
      r = r / w;
    end
    so  = row_major(pos, 1'b0);
    dso = row_major(pos, 1'b1);
    last = (m_run + 64'd1 >= runs);
    push_desc(so * esz, dso * esz, 64'(m_oh[n-1] - m_ol[n-1]) * esz, last, 1'b0);
    if (!last) begin
      m_run  = (m_run + 64'd1) & RunCap;
      m_done = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [47:0] got, exp_v);
    $display("t=%0t %s: got %h, want %h", $time, what, got, exp_v);
    mismatches++;
  endtask

  // Driver: hands the next command over once the previous one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_descriptor(cur_cmd);
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 &&
            ((issued > 600 && issued < 900) || $urandom_range(99) >= 33)) begin
          cur_cmd = pending_cmds.pop_front();
          issued++;
          command_i       <= cur_cmd.cmd;
          src_low_i       <= cur_cmd.sl;
          src_high_i      <= cur_cmd.sh;
          dst_low_i       <= cur_cmd.dl;
          dst_high_i      <= cur_cmd.dh;
          element_bytes_i <= cur_cmd.eb;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every descriptor strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin
    descriptor_t e;
    if (rst_ni && valid_o) begin
      if (expected_descs.size() == 0) begin
        report_mismatch("descriptor with nothing expected", src_byte_offset_o, 48'd0);
      end else begin
        e = expected_descs.pop_front();
        if (src_byte_offset_o !== e.src_off)
          report_mismatch("src_byte_offset", src_byte_offset_o, e.src_off);
        if (dst_byte_offset_o !== e.dst_off)
          report_mismatch("dst_byte_offset", dst_byte_offset_o, e.dst_off);
        if (byte_length_o !== e.len) report_mismatch("byte_length", byte_length_o, e.len);
        if (last_chunk_o !== e.last) report_mismatch("last_chunk", 48'(last_chunk_o), 48'(e.last));
        if (no_overlap_o !== e.none) report_mismatch("no_overlap", 48'(no_overlap_o), 48'(e.none));
      end
    end
  end

  function automatic box_cmd_t mk(input logic [1:0] cmd, input logic [31:0] sl, sh, dl, dh,
                                  input logic [7:0] eb);
    box_cmd_t c;
    c.cmd = cmd; c.sl = sl; c.sh = sh; c.dl = dl; c.dh = dh; c.eb = eb;
    return c;
  endfunction

  task automatic add_fetches(input int unsigned k);
    repeat (k) queue_cmd(mk(CMD_FETCH, $urandom, $urandom, $urandom, $urandom,
                            8'($urandom)));
  endtask

  // One random job: usually a clear, a few dimensions with small overlaps, then fetches.
  task automatic add_random_job();
    logic [31:0] sl, sh, dl, dh;
    int unsigned ndim;
    if ($urandom_range(9) != 0) queue_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 8'd1));
    ndim = ($urandom_range(19) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 4);
    for (int unsigned d = 0; d < ndim; d++) begin
      sl = $urandom_range(1000);
      sh = sl + $urandom_range(1, 4);
      case ($urandom_range(5))
        0, 1, 2: begin dl = sl; dh = sh; end
        3: begin dl = sl - $urandom_range(2); dh = sh + $urandom_range(2); end
        4: begin dl = sh - 1; dh = sh + 3; end
        default: begin dl = sh + $urandom_range(1); dh = dl + 2; end
      endcase
      if ($urandom_range(29) == 0) begin sl = $urandom; sh = $urandom; end
      queue_cmd(mk(CMD_LOAD, sl, sh, dl, dh, 8'($urandom_range(1, 255))));
      if ($urandom_range(19) == 0) add_fetches(1);
    end
    add_fetches($urandom_range(1, 12));
  endtask

  initial begin
    clear_job();
    // Scalar job, exhausted job and the ignored command 3.
    add_fetches(2);
    queue_cmd(mk(CMD_IGNORED, '1, '1, '1, '1, 8'hFF));
    // Single dimension, then a load during the job restarts it.
    queue_cmd(mk(CMD_LOAD, 32'd3, 32'd9, 32'd5, 32'd20, 8'd255));
    add_fetches(1);
    queue_cmd(mk(CMD_LOAD, 32'd0, 32'd4, 32'd1, 32'd4, 8'd1));
    add_fetches(4);
    // Inverted bounds give the empty-overlap descriptor.
    queue_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 8'd1));
    queue_cmd(mk(CMD_LOAD, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 8'd7));
    add_fetches(2);
    // Huge extents over two non-contiguous dimensions exercise wide offsets and lengths.
    queue_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 8'd1));
    queue_cmd(mk(CMD_LOAD, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 8'd255));
    queue_cmd(mk(CMD_LOAD, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE, 8'd255));
    add_fetches(2);
    // More dimensions than the block holds.
    queue_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 8'd1));
    for (int unsigned d = 0; d < 9; d++)
      queue_cmd(mk(CMD_LOAD, 32'd0, 32'd1, 32'd0, 32'd1, 8'(d + 1)));
    add_fetches(2);
    while (pending_cmds.size() < 1650) begin
      if ($urandom_range(9) == 0)
        queue_cmd(mk(2'($urandom), $urandom, $urandom, $urandom, $urandom,
                     8'($urandom_range(1, 255))));
      else
        add_random_job();
    end
    stimulus_ready = 1'b1;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_ready);
    do @(posedge clk_i); while (pending_cmds.size() != 0 || start);
    do @(posedge clk_i); while (expected_descs.size() != 0);
    repeat (40) @(posedge clk_i);
    if (expected_descs.size() != 0) begin
      report_mismatch("descriptors never arrived", 48'(expected_descs.size()), 48'd0);
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("Mismatches found");
    $finish;
  end

endmodule
